### rtl/core/bst_pkg.sv
// bst_pkg: shared constants, codes and handshake structs of the breakpoint slot table
// used by bst_scan and breakpoint_slot_table; depends on nothing else
`timescale 1ns / 1ps

package bst_pkg;

	// table sizes
	localparam int MEM_SLOTS   = 10;
	localparam int HW_SLOTS    = 6;
	localparam int WATCH_SLOTS = 4;

	localparam int MAX_SLOTS_MH = (MEM_SLOTS > HW_SLOTS) ? MEM_SLOTS : HW_SLOTS;
	localparam int MAX_SLOTS    = (MAX_SLOTS_MH > WATCH_SLOTS) ? MAX_SLOTS_MH : WATCH_SLOTS;

	// index widths: shared scan index and per-table indexes
	localparam int IDX_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int MEM_IW   = (MEM_SLOTS > 1) ? $clog2(MEM_SLOTS) : 1;
	localparam int HW_IW    = (HW_SLOTS > 1) ? $clog2(HW_SLOTS) : 1;
	localparam int WATCH_IW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	// kind codes
	localparam logic [2:0] KIND_MEM    = 3'd0;
	localparam logic [2:0] KIND_HW     = 3'd1;
	localparam logic [2:0] KIND_WRITE  = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_ACCESS = 3'd4;

	// status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADKIND  = 3'd4;

	// table select codes
	localparam logic [1:0] TBL_MEM   = 2'd0;
	localparam logic [1:0] TBL_HW    = 2'd1;
	localparam logic [1:0] TBL_WATCH = 2'd2;

	// scan control from the sequencer
	typedef struct packed {
		logic start;
		logic run;
	} scan_ctl_t;

	// scan progress and outcome back to the sequencer
	typedef struct packed {
		logic             last;
		logic [IDX_W-1:0] idx;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

endpackage

### rtl/core/bst_scan.sv
// bst_scan: shared slot scanner, one 32-bit address compare per cycle
// tracks the lowest matching slot and the lowest free slot; depends on bst_pkg
`timescale 1ns / 1ps

module bst_scan import bst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [IDX_W-1:0]  last_idx,
	input  logic              slot_valid,
	input  logic [ADDR_W-1:0] slot_addr,
	input  logic [ADDR_W-1:0] key,
	output scan_res_t         res
);

	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             match;

	// the one shared comparator
	assign match = slot_valid && (slot_addr == key);

	// slot counter and first-hit / first-free trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else if (ctl.start) begin
			idx_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.run) begin
			idx_q <= idx_q + 1'b1;
			if (!hit_q && match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!free_q && !slot_valid) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
	end

	assign res.last     = (idx_q == last_idx);
	assign res.idx      = idx_q;
	assign res.hit      = hit_q;
	assign res.hit_idx  = hit_idx_q;
	assign res.free     = free_q;
	assign res.free_idx = free_idx_q;

endmodule

### rtl/core/breakpoint_slot_table.sv
// breakpoint_slot_table: memory, hardware and watch slot tables with insert/remove/clear/query
// depends on bst_pkg and bst_scan
`timescale 1ns / 1ps
//
// channel   signals                               direction  moves
// input     in_valid in_ready cmd kind address     in         one command transaction
//           watch_size
// output    out_valid out_ready ok status          out        one answer transaction
//
// a scanning command goes through accept, N slot compares through the one
// shared comparator (N = 10, 6 or 4 for the memory, hardware or watch table) and commit;
// clear all and invalid-kind commands go from accept straight to commit
// reset clears all valid bits at once; slot contents never match while invalid
// the answer sits in an output register; the next command can be accepted and
// scanned while it waits, and the commit stalls until the register is free

module breakpoint_slot_table import bst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [2:0]        kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  watch_size,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic [2:0]        status
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        cmd_q;
	logic [2:0]        kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;

	// slot tables
	logic [MEM_SLOTS-1:0]   mem_valid_q;
	logic [ADDR_W-1:0]      mem_addr_q [MEM_SLOTS];
	logic [HW_SLOTS-1:0]    hw_valid_q;
	logic [ADDR_W-1:0]      hw_addr_q [HW_SLOTS];
	logic [WATCH_SLOTS-1:0] watch_valid_q;
	logic [ADDR_W-1:0]      watch_addr_q [WATCH_SLOTS];
	logic [LEN_W-1:0]       watch_len_q [WATCH_SLOTS];
	logic [2:0]             watch_kind_q [WATCH_SLOTS];

	logic        out_valid_q;
	logic        ok_q;
	logic [2:0]  status_q;

	logic              accept;
	logic              direct;
	logic [1:0]        tsel;
	logic [IDX_W-1:0]  last_idx;
	logic              slot_valid;
	logic [ADDR_W-1:0] slot_addr;
	scan_ctl_t         sctl;
	scan_res_t         sres;
	logic              commit;
	logic [2:0]        st;
	logic              clr_all;
	logic              wr_new;
	logic              rm_hit;
	logic              merge;
	logic [MEM_IW-1:0]   mem_hi;
	logic [MEM_IW-1:0]   mem_fi;
	logic [HW_IW-1:0]    hw_hi;
	logic [HW_IW-1:0]    hw_fi;
	logic [WATCH_IW-1:0] w_hi;
	logic [WATCH_IW-1:0] w_fi;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// clear all and bad kinds need no scan
	assign direct   = (cmd == CMD_CLEAR) ||
		(((cmd == CMD_INSERT) || (cmd == CMD_REMOVE)) && (kind > KIND_ACCESS));

	// table selected by the held command
	always_comb begin
		if (cmd_q == CMD_QUERY || kind_q == KIND_MEM) begin
			tsel = TBL_MEM;
		end else if (kind_q == KIND_HW) begin
			tsel = TBL_HW;
		end else begin
			tsel = TBL_WATCH;
		end
	end

	// slot read at the scan index
	always_comb begin
		case (tsel)
			TBL_MEM: begin
				last_idx   = IDX_W'(MEM_SLOTS - 1);
				slot_valid = mem_valid_q[sres.idx[MEM_IW-1:0]];
				slot_addr  = mem_addr_q[sres.idx[MEM_IW-1:0]];
			end
			TBL_HW: begin
				last_idx   = IDX_W'(HW_SLOTS - 1);
				slot_valid = hw_valid_q[sres.idx[HW_IW-1:0]];
				slot_addr  = hw_addr_q[sres.idx[HW_IW-1:0]];
			end
			default: begin
				last_idx   = IDX_W'(WATCH_SLOTS - 1);
				slot_valid = watch_valid_q[sres.idx[WATCH_IW-1:0]];
				slot_addr  = watch_addr_q[sres.idx[WATCH_IW-1:0]];
			end
		endcase
	end

	assign sctl.start = accept;
	assign sctl.run   = (state_q == S_SCAN);

	bst_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sctl),
		.last_idx   (last_idx),
		.slot_valid (slot_valid),
		.slot_addr  (slot_addr),
		.key        (addr_q),
		.res        (sres)
	);

	assign mem_hi = sres.hit_idx[MEM_IW-1:0];
	assign mem_fi = sres.free_idx[MEM_IW-1:0];
	assign hw_hi  = sres.hit_idx[HW_IW-1:0];
	assign hw_fi  = sres.free_idx[HW_IW-1:0];
	assign w_hi   = sres.hit_idx[WATCH_IW-1:0];
	assign w_fi   = sres.free_idx[WATCH_IW-1:0];

	assign commit = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	// command outcome from the scan result
	always_comb begin
		st      = ST_DONE;
		clr_all = 1'b0;
		wr_new  = 1'b0;
		rm_hit  = 1'b0;
		merge   = 1'b0;
		case (cmd_q)
			CMD_CLEAR: begin
				clr_all = 1'b1;
			end
			CMD_QUERY: begin
				st = sres.hit ? ST_DONE : ST_NOTFOUND;
			end
			default: begin
				if (kind_q > KIND_ACCESS) begin
					st = ST_BADKIND;
				end else if (cmd_q == CMD_REMOVE) begin
					st     = sres.hit ? ST_DONE : ST_NOTFOUND;
					rm_hit = sres.hit;
				end else if (sres.hit) begin
					st    = ST_PRESENT;
					merge = (tsel == TBL_WATCH);
				end else if (sres.free) begin
					wr_new = 1'b1;
				end else begin
					st = ST_FULL;
				end
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= direct ? S_COMMIT : S_SCAN;
					end
				end
				S_SCAN: begin
					if (sres.last) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command transaction hold
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			kind_q <= kind;
			addr_q <= address;
			len_q  <= watch_size;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q   <= '0;
			hw_valid_q    <= '0;
			watch_valid_q <= '0;
		end else if (commit) begin
			if (clr_all) begin
				mem_valid_q   <= '0;
				hw_valid_q    <= '0;
				watch_valid_q <= '0;
			end else if (wr_new || rm_hit) begin
				case (tsel)
					TBL_MEM: begin
						mem_valid_q[wr_new ? mem_fi : mem_hi] <= wr_new;
					end
					TBL_HW: begin
						hw_valid_q[wr_new ? hw_fi : hw_hi] <= wr_new;
					end
					default: begin
						watch_valid_q[wr_new ? w_fi : w_hi] <= wr_new;
					end
				endcase
			end
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (commit) begin
			case (tsel)
				TBL_MEM: begin
					if (wr_new) begin
						mem_addr_q[mem_fi] <= addr_q;
					end else if (rm_hit) begin
						mem_addr_q[mem_hi] <= '0;
					end
				end
				TBL_HW: begin
					if (wr_new) begin
						hw_addr_q[hw_fi] <= addr_q;
					end
				end
				default: begin
					if (wr_new) begin
						watch_addr_q[w_fi] <= addr_q;
						watch_len_q[w_fi]  <= len_q;
						watch_kind_q[w_fi] <= kind_q;
					end else if (merge) begin
						// keep the larger range, differing kinds become an access watch
						if (len_q > watch_len_q[w_hi]) begin
							watch_len_q[w_hi] <= len_q;
						end
						if (watch_kind_q[w_hi] != kind_q) begin
							watch_kind_q[w_hi] <= KIND_ACCESS;
						end
					end
				end
			endcase
		end
	end

	// answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q     <= (st == ST_DONE) || (st == ST_PRESENT);
			status_q <= st;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign status    = status_q;

endmodule
